/* rtl/m4v_pkg.sv */
package m4v_pkg;

  localparam int unsigned NumRows  = 4;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned StageLat = 9;

  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [30:0] InfMag   = 31'h7F80_0000;

  localparam logic [63:0] RowReset [NumRegs] = '{
    64'h0000_0000_3F80_0000, 64'h0,
    64'h3F80_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_3F80_0000,
    64'h0,                   64'h3F80_0000_0000_0000
  };

  typedef logic [31:0] fp32_t;

  function automatic logic is_nan(input fp32_t a);
    return a[30:0] > InfMag;
  endfunction

  function automatic logic is_inf(input fp32_t a);
    return a[30:0] == InfMag;
  endfunction

  function automatic logic is_zero(input fp32_t a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] unpack_man(input fp32_t a);
    return {a[30:23] != 8'd0, a[22:0]};
  endfunction

  function automatic logic signed [11:0] unpack_exp(input fp32_t a);
    logic signed [11:0] e;
    if (a[30:23] != 8'd0) begin
      e = signed'({4'd0, a[30:23]}) - 12'sd150;
    end else begin
      e = -12'sd149;
    end
    return e;
  endfunction

  // Index of the highest set bit.
  function automatic logic [5:0] msb_index(input logic [63:0] m);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // Rounds m * 2^e to single precision, nearest even, given the top bit index p.
  function automatic fp32_t round_pack(input logic sgn, input logic signed [11:0] e,
                                       input logic [63:0] m, input logic [5:0] p);
    logic signed [12:0] be;
    logic signed [12:0] sh_a;
    logic signed [12:0] sh_b;
    logic signed [12:0] sh;
    logic signed [12:0] nsh;
    logic [63:0] mask;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] q;
    logic [63:0] fld;
    logic [63:0] bits;
    fp32_t res;
    be   = 13'(e) + signed'({7'd0, p}) + 13'sd127;
    sh_a = signed'({7'd0, p}) - 13'sd23;
    sh_b = -13'sd149 - 13'(e);
    sh   = (sh_b > sh_a) ? sh_b : sh_a;
    nsh  = -sh;
    mask = '0;
    rem  = '0;
    half = '0;
    if (sh > 13'sd62) begin
      q = '0;
    end else if (sh > 13'sd0) begin
      mask = (64'd1 << sh[5:0]) - 64'd1;
      rem  = m & mask;
      half = 64'd1 << (sh[5:0] - 6'd1);
      q    = m >> sh[5:0];
      if (rem > half || (rem == half && q[0])) begin
        q = q + 64'd1;
      end
    end else begin
      q = m << nsh[5:0];
    end
    fld  = (be >= 13'sd1) ? 64'(be - 13'sd1) : 64'd0;
    bits = (fld << 23) + q;
    if (be > 13'sd300 || bits >= {33'd0, InfMag}) begin
      res = {sgn, InfMag};
    end else begin
      res = {sgn, bits[30:0]};
    end
    return res;
  endfunction

endpackage

/* rtl/m4v_in_if.sv */
interface m4v_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] vin_x;
  logic [31:0] vin_y;
  logic [31:0] vin_z;
  logic [31:0] vin_w;
  modport source(output valid, vin_x, vin_y, vin_z, vin_w, input ready);
  modport sink(input valid, vin_x, vin_y, vin_z, vin_w, output ready);
endinterface

/* rtl/m4v_out_if.sv */
interface m4v_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] vout_x;
  logic [31:0] vout_y;
  logic [31:0] vout_z;
  logic [31:0] vout_w;
  modport source(output valid, vout_x, vout_y, vout_z, vout_w, input ready);
  modport sink(input valid, vout_x, vout_y, vout_z, vout_w, output ready);
endinterface

/* rtl/m4v_cfg_if.sv */
interface m4v_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/m4v_fmul.sv */
module m4v_fmul (
  input  logic          clk,
  input  logic          en,
  input  m4v_pkg::fp32_t a,
  input  m4v_pkg::fp32_t b,
  output m4v_pkg::fp32_t res
);
  import m4v_pkg::*;

  logic               s1_spec, s2_spec;
  fp32_t              s1_sval, s2_sval;
  logic               s1_sgn, s2_sgn;
  logic signed [11:0] s1_e, s2_e;
  logic [47:0]        s1_prod, s2_prod;
  logic [5:0]         s2_p;

  logic  sgn;
  logic  spec;
  fp32_t sval;

  always_comb begin
    sgn  = a[31] ^ b[31];
    spec = 1'b1;
    sval = QnanBits;
    if (is_nan(a) || is_nan(b)) begin
      sval = QnanBits;
    end else if (is_inf(a) || is_inf(b)) begin
      sval = (is_zero(a) || is_zero(b)) ? QnanBits : {sgn, InfMag};
    end else if (is_zero(a) || is_zero(b)) begin
      sval = {sgn, 31'd0};
    end else begin
      spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_spec <= spec;
      s1_sval <= sval;
      s1_sgn  <= sgn;
      s1_e    <= unpack_exp(a) + unpack_exp(b);
      s1_prod <= unpack_man(a) * unpack_man(b);
      s2_spec <= s1_spec;
      s2_sval <= s1_sval;
      s2_sgn  <= s1_sgn;
      s2_e    <= s1_e;
      s2_prod <= s1_prod;
      s2_p    <= msb_index({16'd0, s1_prod});
      res     <= s2_spec ? s2_sval : round_pack(s2_sgn, s2_e, {16'd0, s2_prod}, s2_p);
    end
  end

endmodule

/* rtl/m4v_fadd.sv */
module m4v_fadd (
  input  logic          clk,
  input  logic          en,
  input  m4v_pkg::fp32_t a,
  input  m4v_pkg::fp32_t b,
  output m4v_pkg::fp32_t res
);
  import m4v_pkg::*;

  logic               s1_spec, s2_spec;
  fp32_t              s1_sval, s2_sval;
  logic               s1_sgn, s2_sgn;
  logic signed [11:0] s1_e, s2_e;
  logic [60:0]        s1_m, s2_m;
  logic [5:0]         s2_p;

  fp32_t              big, lit;
  logic signed [11:0] eb_big, eb_lit, d;
  logic [60:0]        ma, mb, m;
  logic signed [11:0] e;
  logic               sgn;
  logic               spec;
  fp32_t              sval;

  always_comb begin
    // The larger magnitude goes first so the aligned difference never goes negative.
    if (a[30:0] < b[30:0]) begin
      big = b;
      lit = a;
    end else begin
      big = a;
      lit = b;
    end
    eb_big = unpack_exp(big);
    eb_lit = unpack_exp(lit);
    d      = eb_big - eb_lit;
    if (d <= 12'sd36) begin
      ma = 61'(unpack_man(big)) << d[5:0];
      mb = 61'(unpack_man(lit));
      e  = eb_lit;
    end else begin
      // A far smaller operand only contributes a sticky bit.
      ma = 61'(unpack_man(big)) << 36;
      mb = 61'd1;
      e  = eb_big - 12'sd36;
    end
    sgn = big[31];
    if (big[31] == lit[31]) begin
      m = ma + mb;
    end else if (ma >= mb) begin
      m = ma - mb;
    end else begin
      m   = mb - ma;
      sgn = lit[31];
    end

    spec = 1'b1;
    sval = QnanBits;
    if (is_nan(a) || is_nan(b)) begin
      sval = QnanBits;
    end else if (is_inf(a) && is_inf(b)) begin
      sval = (a[31] == b[31]) ? a : QnanBits;
    end else if (is_inf(a)) begin
      sval = a;
    end else if (is_inf(b)) begin
      sval = b;
    end else if (is_zero(a) && is_zero(b)) begin
      sval = {a[31] & b[31], 31'd0};
    end else if (is_zero(a)) begin
      sval = b;
    end else if (is_zero(b)) begin
      sval = a;
    end else if (m == 61'd0) begin
      sval = 32'd0;
    end else begin
      spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_spec <= spec;
      s1_sval <= sval;
      s1_sgn  <= sgn;
      s1_e    <= e;
      s1_m    <= m;
      s2_spec <= s1_spec;
      s2_sval <= s1_sval;
      s2_sgn  <= s1_sgn;
      s2_e    <= s1_e;
      s2_m    <= s1_m;
      s2_p    <= msb_index({3'd0, s1_m});
      res     <= s2_spec ? s2_sval : round_pack(s2_sgn, s2_e, {3'd0, s2_m}, s2_p);
    end
  end

endmodule

/* rtl/m4v_lane.sv */
module m4v_lane (
  input  logic          clk,
  input  logic          en,
  input  m4v_pkg::fp32_t row [4],
  input  m4v_pkg::fp32_t vec [4],
  output m4v_pkg::fp32_t dot
);
  import m4v_pkg::*;

  fp32_t prod [4];
  fp32_t sum01, sum23;

  for (genvar k = 0; k < 4; k++) begin : g_mul
    m4v_fmul u_mul (.clk(clk), .en(en), .a(row[k]), .b(vec[k]), .res(prod[k]));
  end

  m4v_fadd u_add01 (.clk(clk), .en(en), .a(prod[0]), .b(prod[1]), .res(sum01));
  m4v_fadd u_add23 (.clk(clk), .en(en), .a(prod[2]), .b(prod[3]), .res(sum23));
  m4v_fadd u_addf  (.clk(clk), .en(en), .a(sum01), .b(sum23), .res(dot));

endmodule

/* rtl/mat4_vec4_transform.sv */
// Transforms a stream of single-precision 4-vectors by a stored 4x4 matrix.
// Input requests arrive on vin, results leave on vout; both use valid/ready
// and a request moves at a clock edge where both are high.
// The matrix is loaded through cfg: index 2r holds row r elements 0 and 1,
// index 2r+1 holds elements 2 and 3 (low word first). Indexes above seven
// are accepted and dropped. cfg is always ready; write it only while idle.
// Each of the four rows has its own lane of four multipliers and a two-level
// adder tree, each unit three stages deep. One request is taken every cycle
// while the receiver does not stall.
// The last adder stage is the output register; when the receiver stalls the
// whole pipeline holds and vin.ready drops, so nothing is lost.
// Reset empties the pipeline and loads the identity matrix.
module mat4_vec4_transform (
  input logic       clk,
  input logic       rst,
  m4v_in_if.sink    vin,
  m4v_out_if.source vout,
  m4v_cfg_if.sink   cfg
);
  import m4v_pkg::*;

  logic [63:0]         rows [NumRegs];
  logic [StageLat-1:0] vld;
  logic                en;
  fp32_t               vec [4];
  fp32_t               dots [NumRows];

  assign en        = !vld[StageLat-1] || vout.ready;
  assign vin.ready = en;
  assign cfg.ready = 1'b1;
  assign vec[0]    = vin.vin_x;
  assign vec[1]    = vin.vin_y;
  assign vec[2]    = vin.vin_z;
  assign vec[3]    = vin.vin_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= RowReset;
    end else if (cfg.valid && cfg.index < CfgIdxW'(NumRegs)) begin
      rows[cfg.index[2:0]] <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[StageLat-2:0], vin.valid};
    end
  end

  for (genvar r = 0; r < NumRows; r++) begin : g_lane
    fp32_t row [4];
    assign row[0] = rows[2*r][31:0];
    assign row[1] = rows[2*r][63:32];
    assign row[2] = rows[2*r+1][31:0];
    assign row[3] = rows[2*r+1][63:32];
    m4v_lane u_lane (.clk(clk), .en(en), .row(row), .vec(vec), .dot(dots[r]));
  end

  assign vout.valid  = vld[StageLat-1];
  assign vout.vout_x = dots[0];
  assign vout.vout_y = dots[1];
  assign vout.vout_z = dots[2];
  assign vout.vout_w = dots[3];

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    vin.valid && vin.ready |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  a_reset_identity: assert property (@(posedge clk)
    rst |=> rows[0] == RowReset[0] && rows[7] == RowReset[7])
    else $error("matrix not identity after reset");

endmodule
